// ===== sv/dcd_pkg.sv =====
// Shared types, constants and codes for the document-length chunk decoder.
`default_nettype none

package dcd_pkg;

    // Field widths
    localparam int BYTE_W          = 8;
    localparam int DOC_W           = 32;
    localparam int LEN_W           = 17;
    localparam int ERR_W           = 3;
    localparam int NB_W            = 3;
    localparam int PHASE_W         = 2;
    localparam int MAX_CHUNK_BYTES = 65536;
    localparam int DIV_CNT_W       = $clog2(LEN_W + 1);

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    // Header width byte checks
    localparam logic [BYTE_W-1:0] WIDTH_BASE = 8'd8;
    localparam logic [BYTE_W-1:0] WIDTH_MASK = 8'h18;
    localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hff;
    localparam logic [NB_W-1:0]   MAX_NB     = 3'd4;

    // Result kinds
    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 3'd0,
        ERR_EMPTY = 3'd1,
        ERR_WIDTH = 3'd2,
        ERR_JUNK  = 3'd3,
        ERR_FIRST = 3'd4
    } err_code_t;

    typedef struct packed {
        logic             kind;
        logic [DOC_W-1:0] doc_number;
        logic [DOC_W-1:0] doc_length;
        err_code_t        error_code;
    } result_t;

    // Request to and response from the bit-serial header divider
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [NB_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quotient;
        logic             rem_nz;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/dcd_div_serial.sv =====
// Restoring divider, one quotient bit per cycle, for the chunk value count.
`default_nettype none

module dcd_div_serial (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dcd_pkg::div_req_t req,
    output dcd_pkg::div_rsp_t      rsp
);

    logic [dcd_pkg::LEN_W-1:0]     dvd_reg, dvd_next;
    logic [dcd_pkg::NB_W-1:0]      dvs_reg, dvs_next;
    logic [1:0]                    rem_reg, rem_next;
    logic [dcd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [2:0]                    trial;
    logic [2:0]                    diff;
    logic                          ge;

    // Bring down the next dividend bit and try the divisor
    assign trial = {rem_reg, dvd_reg[dcd_pkg::LEN_W-1]};
    assign diff  = trial - dvs_reg;
    assign ge    = (trial >= dvs_reg);

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rem_next = 2'd0;
            cnt_next = dcd_pkg::DIV_CNT_W'(dcd_pkg::LEN_W);
        end else if (cnt_reg != '0) begin
            // Shift the quotient bit in where the dividend bit left
            dvd_next  = {dvd_reg[dcd_pkg::LEN_W-2:0], ge};
            rem_next  = ge ? diff[1:0] : trial[1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == dcd_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;
    assign rsp.rem_nz   = (rem_reg != 2'd0);

endmodule

`default_nettype wire

// ===== sv/dcd_out_buf.sv =====
// Two-entry result buffer that decouples the decoder from the output stall.
`default_nettype none

module dcd_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire dcd_pkg::result_t push_res,
    output logic                  space,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dcd_pkg::result_t      out_res
);

    dcd_pkg::result_t ent_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign out_res   = ent_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/doclen_chunk_decoder.sv =====
// Top level: document-length chunk decoder, byte-serial value assembly.
//
//  Channel  | Dir | tdata (low bit up)                              | tuser
//  ---------+-----+-------------------------------------------------+-----------
//  s_       | in  | data_byte[7:0], chunk_last_docid[39:8],          | chunk_start
//           |     | chunk_length[56:40], zero pad [63:57]           |
//  m_       | out | doc_number[31:0], doc_length[63:32],            | out_kind
//           |     | error_code[66:64], zero pad [71:67]             |
//
// Values are built one byte per beat. A header beat that passes its
// immediate checks holds the input while the serial divider works out
// the value count one bit per cycle. Reset is synchronous; the decoder
// then drops bytes until a chunk start. Results go into a two-entry buffer;
// input is held only while that buffer is full or the divider is busy.
`default_nettype none

module doclen_chunk_decoder (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // data_byte, chunk_last_docid, chunk_length, zero pad
    input  wire logic [dcd_pkg::S_TDATA_W-1:0]   s_tdata,
    // chunk_start
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // doc_number, doc_length, error_code, zero pad
    output logic [dcd_pkg::M_TDATA_W-1:0]        m_tdata,
    // out_kind
    output logic                                 m_tuser
);

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [dcd_pkg::NB_W-1:0]        nb_reg, nb_next;
    logic [dcd_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [dcd_pkg::DOC_W-1:0]       acc_reg, acc_next;
    logic                            ones_reg, ones_next;
    logic [dcd_pkg::DOC_W-1:0]       doc_reg, doc_next;
    logic [dcd_pkg::LEN_W-1:0]       left_reg, left_next;
    logic                            drop_reg, drop_next;
    logic                            first_reg, first_next;

    logic [dcd_pkg::BYTE_W-1:0]      in_byte;
    logic [dcd_pkg::DOC_W-1:0]       in_last;
    logic [dcd_pkg::LEN_W-1:0]       in_len;
    logic                            accept;
    logic                            width_ok;
    logic [dcd_pkg::DOC_W-1:0]       acc_shift;
    logic                            ones_new;
    logic [dcd_pkg::LEN_W-1:0]       left_dec;

    dcd_pkg::div_req_t               div_req;
    dcd_pkg::div_rsp_t               div_rsp;
    logic                            push;
    dcd_pkg::result_t                push_res;
    logic                            buf_space;
    dcd_pkg::result_t                buf_res;

    assign in_byte = s_tdata[7:0];
    assign in_last = s_tdata[39:8];
    assign in_len  = s_tdata[56:40];

    assign s_tready = (state_reg == ST_RUN) && buf_space;
    assign accept   = s_tvalid && s_tready;

    // Header width must be 8, 16, 24 or 32
    assign width_ok  = ((in_byte - dcd_pkg::WIDTH_BASE) & ~dcd_pkg::WIDTH_MASK) == '0;
    assign acc_shift = {acc_reg[dcd_pkg::DOC_W-dcd_pkg::BYTE_W-1:0], in_byte};
    assign ones_new  = ones_reg && (in_byte == dcd_pkg::BYTE_ONES);
    assign left_dec  = left_reg - 1'b1;

    always_comb begin
        state_next = state_reg;
        nb_next    = nb_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ones_next  = ones_reg;
        doc_next   = doc_reg;
        left_next  = left_reg;
        drop_next  = drop_reg;
        first_next = first_reg;
        div_req    = '0;
        push       = 1'b0;
        push_res   = '0;

        case (state_reg)
            ST_RUN: begin
                if (accept && s_tuser) begin
                    // Chunk header: clear value state, check what can be checked now
                    phase_next = '0;
                    acc_next   = '0;
                    ones_next  = 1'b1;
                    first_next = 1'b0;
                    left_next  = '0;
                    drop_next  = 1'b1;
                    if (in_last == '0) begin
                        drop_next = 1'b1;
                    end else if (in_len == '0) begin
                        push                = 1'b1;
                        push_res.kind       = dcd_pkg::KIND_ERROR;
                        push_res.error_code = dcd_pkg::ERR_EMPTY;
                    end else if (!width_ok) begin
                        push                = 1'b1;
                        push_res.kind       = dcd_pkg::KIND_ERROR;
                        push_res.error_code = dcd_pkg::ERR_WIDTH;
                    end else begin
                        nb_next = in_byte[5:3];
                        if (32'(in_len) > 32'(dcd_pkg::MAX_CHUNK_BYTES)) begin
                            push                = 1'b1;
                            push_res.kind       = dcd_pkg::KIND_ERROR;
                            push_res.error_code = dcd_pkg::ERR_JUNK;
                        end else if (in_len == dcd_pkg::LEN_W'(1)) begin
                            push                = 1'b1;
                            push_res.kind       = dcd_pkg::KIND_ERROR;
                            push_res.error_code = dcd_pkg::ERR_FIRST;
                        end else begin
                            // Hand the byte count to the divider, park last docid
                            div_req.start    = 1'b1;
                            div_req.dividend = in_len - 1'b1;
                            div_req.divisor  = in_byte[5:3];
                            doc_next         = in_last;
                            left_next        = in_len - 1'b1;
                            state_next       = ST_DIV;
                        end
                    end
                end else if (accept) begin
                    if (drop_reg || (left_reg == '0) || (nb_reg == '0)
                        || (nb_reg > dcd_pkg::MAX_NB)) begin
                        drop_next = 1'b1;
                    end else begin
                        left_next = left_dec;
                        if (({1'b0, phase_reg} + 3'd1) < nb_reg) begin
                            // Middle byte of a value: shift in and wait
                            phase_next = phase_reg + 1'b1;
                            acc_next   = acc_shift;
                            ones_next  = ones_new;
                        end else begin
                            // Last byte of a value
                            phase_next = '0;
                            acc_next   = '0;
                            ones_next  = 1'b1;
                            doc_next   = doc_reg + 1'b1;
                            first_next = 1'b0;
                            if (!ones_new) begin
                                push                = 1'b1;
                                push_res.kind       = dcd_pkg::KIND_ENTRY;
                                push_res.doc_number = doc_reg;
                                push_res.doc_length = acc_shift;
                                push_res.error_code = dcd_pkg::ERR_NONE;
                                if (left_dec == '0) begin
                                    drop_next = 1'b1;
                                end
                            end else if (first_reg) begin
                                push                = 1'b1;
                                push_res.kind       = dcd_pkg::KIND_ERROR;
                                push_res.error_code = dcd_pkg::ERR_FIRST;
                                drop_next           = 1'b1;
                            end else if (left_dec == '0) begin
                                drop_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_RUN;
                    if (div_rsp.rem_nz) begin
                        push                = 1'b1;
                        push_res.kind       = dcd_pkg::KIND_ERROR;
                        push_res.error_code = dcd_pkg::ERR_JUNK;
                        left_next           = '0;
                    end else begin
                        // First docid = last - count + 1
                        doc_next   = doc_reg - dcd_pkg::DOC_W'(div_rsp.quotient) + 1'b1;
                        first_next = 1'b1;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            nb_reg    <= '0;
            phase_reg <= '0;
            acc_reg   <= '0;
            ones_reg  <= 1'b1;
            doc_reg   <= '0;
            left_reg  <= '0;
            drop_reg  <= 1'b1;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ones_reg  <= ones_next;
            doc_reg   <= doc_next;
            left_reg  <= left_next;
            drop_reg  <= drop_next;
            first_reg <= first_next;
        end
    end

    dcd_div_serial u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    dcd_out_buf u_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_res  (push_res),
        .space     (buf_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (buf_res)
    );

    // Pack the result beat
    assign m_tuser = buf_res.kind;
    assign m_tdata = {{(dcd_pkg::M_TDATA_W - 2*dcd_pkg::DOC_W - dcd_pkg::ERR_W){1'b0}},
                      buf_res.error_code, buf_res.doc_length, buf_res.doc_number};

endmodule

`default_nettype wire

// ===== sv/dcd_checker.sv =====
// Port-level checker for the chunk decoder, bound to the top level.
`default_nettype none

module dcd_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [dcd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [dcd_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          m_tuser
);

    // No result beat survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // Error beats carry a non-zero code and no document fields
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[63:0] == 64'd0) && (m_tdata[66:64] != 3'd0)
            && (m_tdata[66:64] != 3'd5) && (m_tdata[66:64] != 3'd6)
            && (m_tdata[66:64] != 3'd7))
        else $error("malformed error beat");

    // Entry beats carry no error code and a zero pad
    a_entry_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[71:64] == 8'd0))
        else $error("entry beat carries error code");

    // An accepted header with a good width and length keeps the input held
    a_header_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && (s_tdata[39:8] != 32'd0)
            && (s_tdata[56:40] > 17'd1) && (s_tdata[56:40] <= 17'd65536)
            && ((s_tdata[7:0] == 8'd8) || (s_tdata[7:0] == 8'd16)
                || (s_tdata[7:0] == 8'd24) || (s_tdata[7:0] == 8'd32))
        |=> !s_tready)
        else $error("input not held during header division");

endmodule

bind doclen_chunk_decoder dcd_checker u_dcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/tb_doclen_chunk_decoder.sv =====
// Self-checking testbench for the document-length chunk decoder: chunk streams against a predictor.
`timescale 1ns / 100ps

module tb_doclen_chunk_decoder;

    localparam int LIVE_BEATS  = 1850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 50;
    localparam int HOLD_CYCLES = 400;

    // One pending input beat, or a marker that pauses the sender until drained
    typedef struct {
        bit                         drain;
        bit                         start;
        logic [dcd_pkg::BYTE_W-1:0] data;
        logic [dcd_pkg::DOC_W-1:0]  last;
        logic [dcd_pkg::LEN_W-1:0]  len;
    } beat_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [dcd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dcd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    beat_t            pending_beats[$];
    dcd_pkg::result_t expected_results[$];

    int  live_beats     = 0;
    int  accepted_beats = 0;
    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    bit  sender_burst   = 1'b0;
    bit  receiver_burst = 1'b0;
    bit  hold_rx        = 1'b0;
    bit  in_fire        = 1'b0;

    // Predicted decoder state
    logic [dcd_pkg::NB_W-1:0]    width_bytes = '0;
    logic [dcd_pkg::PHASE_W-1:0] phase       = '0;
    logic [dcd_pkg::DOC_W-1:0]   shift_value = '0;
    logic [dcd_pkg::DOC_W-1:0]   next_doc    = '0;
    logic [dcd_pkg::LEN_W-1:0]   bytes_to_go = '0;
    logic                        skipping    = 1'b1;
    logic                        first_due   = 1'b0;

    doclen_chunk_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void note_result(input logic kind,
                                        input logic [dcd_pkg::DOC_W-1:0] doc,
                                        input logic [dcd_pkg::DOC_W-1:0] len,
                                        input dcd_pkg::err_code_t code);
        dcd_pkg::result_t r;
        r.kind       = kind;
        r.doc_number = doc;
        r.doc_length = len;
        r.error_code = code;
        expected_results.push_back(r);
    endfunction

    function automatic void raise_error(input dcd_pkg::err_code_t code);
        skipping = 1'b1;
        note_result(dcd_pkg::KIND_ERROR, '0, '0, code);
    endfunction

    // Advance the predicted state by one accepted beat
    function automatic void decode_beat(input logic start,
                                        input logic [dcd_pkg::BYTE_W-1:0] b,
                                        input logic [dcd_pkg::DOC_W-1:0] last,
                                        input logic [dcd_pkg::LEN_W-1:0] len);
        logic [31:0] width_check;
        logic [31:0] len_less;
        logic [31:0] value_count;
        logic [31:0] val;
        logic [31:0] doc;
        logic [31:0] ones;
        if (start) begin
            phase       = '0;
            shift_value = '0;
            first_due   = 1'b0;
            bytes_to_go = '0;
            skipping    = 1'b1;
            width_check = {24'h0, b} - 32'd8;
            len_less    = {15'h0, len} - 32'd1;
            if (last == 0) begin
                // chunk ignored without a word
            end else if (len == 0) begin
                raise_error(dcd_pkg::ERR_EMPTY);
            end else if ((width_check & ~32'h18) != 0) begin
                raise_error(dcd_pkg::ERR_WIDTH);
            end else begin
                width_bytes = b[5:3];
                if (len > dcd_pkg::MAX_CHUNK_BYTES || (len_less % width_bytes) != 0) begin
                    raise_error(dcd_pkg::ERR_JUNK);
                end else if (len == 1) begin
                    raise_error(dcd_pkg::ERR_FIRST);
                end else begin
                    value_count = len_less / width_bytes;
                    next_doc    = last - value_count + 32'd1;
                    bytes_to_go = len - 1'b1;
                    first_due   = 1'b1;
                    skipping    = 1'b0;
                end
            end
        end else if (skipping || bytes_to_go == 0 || width_bytes == 0
                     || width_bytes > dcd_pkg::MAX_NB) begin
            skipping = 1'b1;
        end else begin
            shift_value = {shift_value[23:0], b};
            bytes_to_go = bytes_to_go - 1'b1;
            if (phase + 1 < width_bytes) begin
                phase = phase + 1'b1;
            end else begin
                val         = shift_value;
                doc         = next_doc;
                phase       = '0;
                shift_value = '0;
                next_doc    = next_doc + 32'd1;
                ones = (width_bytes == dcd_pkg::MAX_NB) ? 32'hFFFF_FFFF
                                                        : (32'h1 << (8 * width_bytes)) - 32'h1;
                // all-ones marks a missing document, fatal only as the first value
                if (val == ones && first_due) begin
                    first_due = 1'b0;
                    raise_error(dcd_pkg::ERR_FIRST);
                end else begin
                    if (val != ones)
                        note_result(dcd_pkg::KIND_ENTRY, doc, val, dcd_pkg::ERR_NONE);
                    first_due = 1'b0;
                    if (bytes_to_go == 0)
                        skipping = 1'b1;
                end
            end
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [dcd_pkg::DOC_W-1:0] pick_last();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom;
        else if (r < 88)
            return 32'($urandom_range(1, 30));
        else if (r < 95)
            return 32'hFFFF_FFFF - 32'($urandom_range(0, 5));
        else
            return 32'h0;
    endfunction

    // Bias lengths towards the sentinel, its neighbour and zero
    function automatic logic [dcd_pkg::DOC_W-1:0] pick_length(input int nb);
        logic [31:0] top;
        int          r;
        top = (nb == 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * nb)) - 32'h1;
        r   = $urandom_range(0, 99);
        if (r < 15)
            return top;
        else if (r < 25)
            return top - 32'h1;
        else if (r < 33)
            return 32'h0;
        else
            return $urandom & top;
    endfunction

    task automatic queue_beat(input bit start, input logic [dcd_pkg::BYTE_W-1:0] data,
                              input logic [dcd_pkg::DOC_W-1:0] last,
                              input logic [dcd_pkg::LEN_W-1:0] len,
                              input bit live);
        beat_t bt;
        bt.drain = 1'b0;
        bt.start = start;
        bt.data  = data;
        bt.last  = last;
        bt.len   = len;
        pending_beats.push_back(bt);
        if (live)
            live_beats++;
    endtask

    task automatic queue_drain();
        beat_t bt;
        bt       = '{default: '0};
        bt.drain = 1'b1;
        pending_beats.push_back(bt);
    endtask

    // Value beats carry don't-care header fields
    task automatic queue_value(input logic [dcd_pkg::BYTE_W-1:0] data, input bit live);
        queue_beat(1'b0, data, $urandom, 17'($urandom_range(0, dcd_pkg::MAX_CHUNK_BYTES)),
                   live);
    endtask

    // Header plus up to nbytes big-endian value bytes of a chunk of count values
    task automatic queue_chunk(input int nb, input int count,
                               input logic [dcd_pkg::DOC_W-1:0] last, input int nbytes);
        logic [31:0] v;
        int          sent;
        sent = 0;
        queue_beat(1'b1, 8'(nb * 8), last, 17'(1 + nb * count), 1'b1);
        for (int i = 0; i < count && sent < nbytes; i++) begin
            v = pick_length(nb);
            for (int k = nb - 1; k >= 0 && sent < nbytes; k--) begin
                queue_value(v[8*k +: 8], 1'b1);
                sent++;
            end
        end
    endtask

    // Sender: present beats at the falling edge, hold until taken
    always @(negedge aclk) begin : driver
        beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap = 0;
        end else if (!(s_tvalid && !in_fire)) begin
            if (s_tvalid)
                send_gap = sender_burst ? 0 : pick_idle();
            if ($urandom_range(0, 149) == 0)
                sender_burst = !sender_burst;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_beats[0].drain) begin
                s_tvalid <= 1'b0;
                if (expected_results.size() == 0)
                    void'(pending_beats.pop_front());
            end else begin
                nxt = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.start;
                s_tdata  <= {7'h0, nxt.len, nxt.last, nxt.data};
            end
        end
    end

    // Receiver: random back-pressure, plus the long hold-off
    always @(negedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_rx) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 149) == 0)
                receiver_burst = !receiver_burst;
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (!receiver_burst && $urandom_range(0, 3) == 0) begin
                recv_gap = pick_idle();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: check result beats, then predict from accepted input beats
    always @(posedge aclk) begin : monitor
        dcd_pkg::result_t want;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: kind %0b tdata %h", m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("out_kind: expected %0b, got %0b", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== want.doc_number) begin
                        $error("doc_number: expected %h, got %h", want.doc_number,
                               m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== want.doc_length) begin
                        $error("doc_length: expected %h, got %h", want.doc_length,
                               m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[66:64] !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d", want.error_code,
                               m_tdata[66:64]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                accepted_beats++;
                decode_beat(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[56:40]);
            end
        end
    end

    // Stall the result side for a long stretch mid-run
    initial begin
        wait (accepted_beats >= 800);
        @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[doclen_chunk_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        int  r;
        int  nb;
        int  count;
        int  pad;
        bit  drained;
        drained = 1'b0;

        // Directed: stray byte before any chunk, silent chunk, each header error
        queue_value(8'hA5, 1'b1);
        queue_beat(1'b1, 8'd8, 32'h0, 17'd5, 1'b1);
        queue_beat(1'b1, 8'd8, 32'h10, 17'd0, 1'b1);
        queue_beat(1'b1, 8'h07, 32'h10, 17'd9, 1'b1);
        queue_beat(1'b1, 8'd16, 32'h20, 17'd4, 1'b1);
        queue_beat(1'b1, 8'd16, 32'hFFFF_FFFF, 17'd65536, 1'b1);
        // Length past the chunk limit
        queue_beat(1'b1, 8'd16, 32'h40, 17'd70001, 1'b1);
        queue_beat(1'b1, 8'd8, 32'h5, 17'd1, 1'b1);
        // First document wraps below zero; a missing document in the middle; byte past the end
        queue_beat(1'b1, 8'd8, 32'h1, 17'd4, 1'b1);
        queue_value(8'h00, 1'b1);
        queue_value(8'hFF, 1'b1);
        queue_value(8'h7F, 1'b1);
        queue_value(8'h33, 1'b1);
        // First value all ones
        queue_beat(1'b1, 8'd32, 32'hFFFF_FFFF, 17'd9, 1'b1);
        repeat (4) queue_value(8'hFF, 1'b1);
        // Largest 24-bit length, then a partial value cut off by a restart
        queue_beat(1'b1, 8'd24, 32'd100, 17'd7, 1'b1);
        queue_value(8'hFF, 1'b1);
        queue_value(8'hFF, 1'b1);
        queue_value(8'hFE, 1'b1);
        queue_value(8'h12, 1'b1);
        queue_beat(1'b1, 8'd32, 32'hFFFF_FFFF, 17'd5, 1'b1);
        queue_value(8'hFF, 1'b1);
        queue_value(8'hFF, 1'b1);
        queue_value(8'hFF, 1'b1);
        queue_value(8'hFE, 1'b1);
        queue_drain();

        // Random: mostly well-formed chunks, some cut short, bad headers and noise
        while (live_beats < LIVE_BEATS) begin
            if (!drained && live_beats > 1300) begin
                queue_drain();
                drained = 1'b1;
            end
            r  = $urandom_range(0, 99);
            nb = $urandom_range(1, 4);
            if (r < 70) begin
                count = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                     : $urandom_range(7, 24);
                queue_chunk(nb, count, pick_last(), nb * count);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) queue_value(8'($urandom), 1'b0);
            end else if (r < 80) begin
                count = $urandom_range(1, 65535 / nb);
                queue_chunk(nb, count, pick_last(), $urandom_range(0, 3 * nb));
            end else if (r < 90) begin
                case ($urandom_range(0, 3))
                    0: begin
                        queue_beat(1'b1, 8'($urandom), pick_last(),
                                   17'($urandom_range(0, dcd_pkg::MAX_CHUNK_BYTES)), 1'b1);
                    end
                    1: begin
                        queue_beat(1'b1, 8'(nb * 8), pick_last(), 17'd0, 1'b1);
                    end
                    2: begin
                        nb  = $urandom_range(2, 4);
                        pad = $urandom_range(1, nb - 1);
                        queue_beat(1'b1, 8'(nb * 8), pick_last(),
                                   17'(1 + nb * $urandom_range(0, 400) + pad), 1'b1);
                    end
                    default: begin
                        queue_beat(1'b1, 8'(nb * 8), pick_last(), 17'd1, 1'b1);
                    end
                endcase
                repeat ($urandom_range(0, 2)) queue_value(8'($urandom), 1'b0);
            end else begin
                queue_beat(1'($urandom_range(0, 1)), 8'($urandom), $urandom,
                           17'($urandom_range(0, dcd_pkg::MAX_CHUNK_BYTES)), 1'b0);
            end
        end

        // Release reset at a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the stimulus to go in and the results to come out
        while (pending_beats.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[doclen_chunk_decoder] OK");
        end else begin
            $display("[doclen_chunk_decoder] ERROR");
        end
        $finish;
    end

endmodule
